@@ sv/skht_pkg.sv @@
// ----------------------------------------------------------------------------
// skht_pkg
// Shared types, constants and the crypt ROM builder for the string key
// hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package skht_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = ADDR_W + 1;
    localparam int POS_W       = 10;
    localparam int HASH_W      = 32;
    localparam int NUM_LANES   = 3;
    localparam int ROM_ROWS    = 256 * NUM_LANES;

    localparam logic [HASH_W-1:0] SEED_ONE_INIT = 32'h7FED7FED;
    localparam logic [HASH_W-1:0] SEED_TWO_INIT = 32'hEEEEEEEE;
    localparam logic [HASH_W-1:0] ROM_SEED      = 32'h00100001;
    localparam logic [HASH_W-1:0] ROM_MULT      = 32'd125;
    localparam logic [HASH_W-1:0] ROM_MOD       = 32'h002AAAAB;
    localparam logic [LEN_W-1:0]  LEN_RESET     = LEN_W'(1024);

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] key_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] slot_position;
    } t_out;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  len;
        logic [HASH_W-1:0] hash_a;
        logic [HASH_W-1:0] hash_b;
    } t_probe;

    typedef logic [ROM_ROWS-1:0][HASH_W-1:0] t_rom;

    function automatic t_rom build_rom();
        t_rom        rom;
        logic [31:0] s;
        logic [31:0] hi;
        logic [31:0] lo;
        rom = '0;
        s   = ROM_SEED;
        for (int row = 0; row < 256; row++) begin
            for (int k = 0; k < 5; k++) begin
                s  = (s * ROM_MULT + 32'd3) % ROM_MOD;
                hi = {s[15:0], 16'h0000};
                s  = (s * ROM_MULT + 32'd3) % ROM_MOD;
                lo = {16'h0000, s[15:0]};
                if (k < NUM_LANES) begin
                    rom[row + k * 256] = hi | lo;
                end
            end
        end
        return rom;
    endfunction

    localparam t_rom CRYPT_ROM = build_rom();

endpackage

`default_nettype wire

@@ sv/skht_hash.sv @@
// ----------------------------------------------------------------------------
// skht_hash
// Three one-way hash lanes, one key byte per cycle in which i_step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module skht_hash
    import skht_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic              i_last,
    input  wire logic [7:0]        i_byte,
    output logic      [HASH_W-1:0] o_hash [NUM_LANES]
);

    logic [HASH_W-1:0] r_seed1 [NUM_LANES];
    logic [HASH_W-1:0] r_seed2 [NUM_LANES];
    logic [HASH_W-1:0] n_seed1 [NUM_LANES];
    logic [HASH_W-1:0] n_seed2 [NUM_LANES];
    logic [7:0]        w_ch;

    assign w_ch = (i_byte >= 8'h61 && i_byte <= 8'h7A) ? i_byte - 8'h20 : i_byte;

    for (genvar t = 0; t < NUM_LANES; t++) begin : g_lane
        always_comb begin
            n_seed1[t] = CRYPT_ROM[{2'(t), w_ch}] ^ (r_seed1[t] + r_seed2[t]);
            n_seed2[t] = {24'h0, w_ch} + n_seed1[t] + r_seed2[t]
                       + {r_seed2[t][HASH_W-6:0], 5'b0} + 32'd3;
        end

        assign o_hash[t] = n_seed1[t];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_seed1[t] <= SEED_ONE_INIT;
                r_seed2[t] <= SEED_TWO_INIT;
            end else if (i_step) begin
                r_seed1[t] <= i_last ? SEED_ONE_INIT : n_seed1[t];
                r_seed2[t] <= i_last ? SEED_TWO_INIT : n_seed2[t];
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/skht_mod.sv @@
// ----------------------------------------------------------------------------
// skht_mod
// Restoring 32-bit modulo by the table length, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module skht_mod
    import skht_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [HASH_W-1:0] i_dividend,
    input  wire logic [LEN_W-1:0]  i_len,
    output logic                   o_done,
    output logic      [ADDR_W-1:0] o_rem
);

    logic                      r_busy;
    logic [$clog2(HASH_W)-1:0] r_cnt;
    logic [HASH_W-1:0]         r_num;
    logic [LEN_W-1:0]          r_len;
    logic [LEN_W-1:0]          r_rem;
    logic [LEN_W:0]            w_trial;
    logic [LEN_W-1:0]          n_rem;

    assign w_trial = {r_rem, r_num[HASH_W-1]};
    assign n_rem   = (w_trial >= {1'b0, r_len}) ? LEN_W'(w_trial - {1'b0, r_len})
                                               : w_trial[LEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
                r_num  <= i_dividend;
                r_len  <= i_len;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_num <= {r_num[HASH_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_rem = r_rem[ADDR_W-1:0];

endmodule

`default_nettype wire

@@ sv/skht_table.sv @@
// ----------------------------------------------------------------------------
// skht_table
// Slot memory with clearing pass and linear probe sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module skht_table
    import skht_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire t_probe i_req,
    input  wire logic   i_res_ready,
    output logic        o_res_valid,
    output t_out        o_res,
    output logic        o_clr_busy
);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_CHK  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam int ENTRY_W = 1 + 2 * HASH_W;

    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;

    logic [2:0]        r_state;
    logic [ADDR_W-1:0] r_clr_cnt;
    logic [ADDR_W-1:0] r_pos;
    t_probe            r_req;
    t_out              r_res;

    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [ENTRY_W-1:0] w_wr_data;
    logic [ADDR_W-1:0] w_next;
    logic              w_valid;
    logic              w_match;
    logic              w_wrap;

    assign w_valid = r_rd_data[ENTRY_W-1];
    assign w_match = r_rd_data[2*HASH_W-1:HASH_W] == r_req.hash_a
                  && r_rd_data[HASH_W-1:0] == r_req.hash_b;
    assign w_next  = (LEN_W'(r_pos) + 1'b1 == r_req.len) ? '0 : r_pos + 1'b1;
    assign w_wrap  = w_next == r_req.start;

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_pos;
        w_wr_data = {1'b1, r_req.hash_a, r_req.hash_b};
        if (r_state == ST_CLR) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_cnt;
            w_wr_data = '0;
        end else if (r_state == ST_CHK && r_req.op == OP_INSERT && !w_valid) begin
            w_wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_clr_cnt <= '0;
        end else begin
            unique case (r_state)
                ST_CLR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (r_clr_cnt == ADDR_W'(TABLE_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_start) begin
                        r_req   <= i_req;
                        r_pos   <= i_req.start;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    if (!w_valid) begin
                        r_res.hit           <= r_req.op == OP_INSERT;
                        r_res.slot_position <= (r_req.op == OP_INSERT) ? POS_W'(r_pos) : '0;
                        r_state             <= ST_DONE;
                    end else if (r_req.op == OP_LOOKUP && w_match) begin
                        r_res.hit           <= 1'b1;
                        r_res.slot_position <= POS_W'(r_pos);
                        r_state             <= ST_DONE;
                    end else if (w_wrap) begin
                        r_res   <= '0;
                        r_state <= ST_DONE;
                    end else begin
                        r_pos   <= w_next;
                        r_state <= ST_READ;
                    end
                end
                ST_DONE: begin
                    if (i_res_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid = r_state == ST_DONE;
    assign o_res       = r_res;
    assign o_clr_busy  = r_state == ST_CLR;

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHK) |-> (LEN_W'(r_pos) < r_req.len))
        else $error("probe position beyond table length");

    a_miss_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.hit) |-> (o_res.slot_position == '0))
        else $error("miss with nonzero position");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == ST_CLR || r_state == ST_CHK))
        else $error("slot write outside clear or probe");

    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHK) |-> ($past(r_state) == ST_READ))
        else $error("check without read");

endmodule

`default_nettype wire

@@ sv/string_key_hash_table_top.sv @@
// ----------------------------------------------------------------------------
// string_key_hash_table_top
// String keyed hash table with MPQ style one-way hashes and linear probing.
//
//   channel  direction  handshake               word
//   in       input      i_in_valid/o_in_ready   t_in  (opcode, key_byte, last_byte)
//   out      output     o_out_valid/i_out_ready t_out (hit, slot_position)
//   cfg      input      i_cfg_valid/o_cfg_ready 11-bit table_length
//
// Key bytes other than the last are taken one per cycle.
// A last byte starts the modulo; each probed slot then passes ST_READ and ST_CHK,
// and the result goes via ST_DONE to o_out_valid, when the next word can be taken.
// The probe walk is bound by the single read port of the slot memory.
// After reset a clearing pass writes every slot while o_in_ready is low.
// A waiting output word holds the next result in the table; input stalls
// until that result moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module string_key_hash_table_top
    import skht_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in              i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out                  o_out_data,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [LEN_W-1:0] i_cfg_data
);

    logic [LEN_W-1:0]  r_table_length;
    logic [LEN_W-1:0]  w_len;
    logic              r_busy;
    logic              r_out_valid;
    t_out              r_out_data;
    t_probe            r_req;
    logic              w_in_acc;
    logic              w_last_acc;
    logic [HASH_W-1:0] w_hash [NUM_LANES];
    logic              w_mod_done;
    logic [ADDR_W-1:0] w_rem;
    t_probe            w_req;
    logic              w_res_valid;
    logic              w_res_ready;
    t_out              w_res;
    logic              w_clr_busy;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        priority if (r_table_length == '0) begin
            w_len = LEN_W'(1);
        end else if (r_table_length > LEN_W'(TABLE_DEPTH)) begin
            w_len = LEN_W'(TABLE_DEPTH);
        end else begin
            w_len = r_table_length;
        end
    end

    assign o_in_ready = !w_clr_busy && !r_busy;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_last_acc = w_in_acc && i_in_data.last_byte;
    assign w_res_ready = !r_out_valid || i_out_ready;

    skht_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_in_acc),
        .i_last  (i_in_data.last_byte),
        .i_byte  (i_in_data.key_byte),
        .o_hash  (w_hash)
    );

    skht_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_last_acc),
        .i_dividend (w_hash[0]),
        .i_len      (w_len),
        .o_done     (w_mod_done),
        .o_rem      (w_rem)
    );

    always_comb begin
        w_req       = r_req;
        w_req.start = w_rem;
    end

    skht_table u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_mod_done),
        .i_req       (w_req),
        .i_res_ready (w_res_ready),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_clr_busy  (w_clr_busy)
    );

    always_ff @(posedge i_clk) begin
        if (w_last_acc) begin
            r_req.op     <= i_in_data.opcode;
            r_req.len    <= w_len;
            r_req.hash_a <= w_hash[1];
            r_req.hash_b <= w_hash[2];
            r_req.start  <= '0;
        end
        if (w_res_valid && w_res_ready) begin
            r_out_data <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_length <= LEN_RESET;
            r_busy         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_table_length <= i_cfg_data;
            end
            if (w_last_acc) begin
                r_busy <= 1'b1;
            end else if (w_res_valid && w_res_ready) begin
                r_busy <= 1'b0;
            end
            if (w_res_valid && w_res_ready) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire
